FILE: rtl/lcs_pkg.sv
// Shared types and codes for the LRU cache set core.
package lcs_pkg;

    // Way index and rank fields on the cell chain cover up to 16 ways.
    localparam int IDX_W     = 4;
    localparam int OUT_WAY_W = 3;
    localparam int ST_W      = 3;

    localparam logic [ST_W-1:0] ST_INVALID = 3'd0;
    localparam logic [ST_W-1:0] ST_VALID   = 3'd1;

    typedef enum logic [1:0] {
        CMD_READ       = 2'd0,
        CMD_WRITE      = 2'd1,
        CMD_SET_STATUS = 2'd2,
        CMD_QUERY      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_READ_HIT   = 3'd0,
        EV_READ_MISS  = 3'd1,
        EV_WRITE_HIT  = 3'd2,
        EV_WRITE_MISS = 3'd3,
        EV_STATUS_SET = 3'd4,
        EV_QUERY      = 3'd5
    } ev_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_PROMOTE,
        UPD_RELEASE,
        UPD_SET_STATUS
    } upd_kind_t;

    // Lookup results rippled from cell 0 up through the row.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_way;
        logic [IDX_W-1:0] hit_rank;
        logic [ST_W-1:0]  hit_status;
        logic             free_ok;
        logic [IDX_W-1:0] free_way;
        logic [IDX_W-1:0] lru_way;
    } chain_t;

    // Update broadcast to every cell.
    typedef struct packed {
        upd_kind_t        kind;
        logic [IDX_W-1:0] way;
        logic [IDX_W-1:0] pivot;
        logic             status_we;
        logic [ST_W-1:0]  status;
        logic             tag_we;
    } upd_t;

endpackage

FILE: rtl/lcs_req_if.sv
// Request channel: command, tag and new status.
interface lcs_req_if #(
    parameter int TAG_BITS = 52
);
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [TAG_BITS-1:0] tag;
    logic [2:0]          new_status;

    modport source (output valid, output cmd, output tag, output new_status, input ready);
    modport sink   (input valid, input cmd, input tag, input new_status, output ready);
endinterface

FILE: rtl/lcs_rsp_if.sv
// Response channel: event code, hit flag, way, eviction flag and status.
interface lcs_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       found;
    logic [2:0] way;
    logic       evicted;
    logic [2:0] status_out;

    modport source (output valid, output event_res, output found, output way,
                    output evicted, output status_out, input ready);
    modport sink   (input valid, input event_res, input found, input way,
                    input evicted, input status_out, output ready);
endinterface

FILE: rtl/lcs_line_cell.sv
// One cache line: tag, status and recency rank, with its link in the lookup chain.
module lcs_line_cell
    import lcs_pkg::*;
#(
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 52,
    parameter int IDX      = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TAG_BITS-1:0] tag,
    input  chain_t              chain_in,
    output chain_t              chain_out,
    input  upd_t                upd
);

    localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [RW-1:0]    LAST_RANK = RW'(WAYS - 1);
    localparam logic [IDX_W-1:0] MY_IDX    = IDX_W'(IDX);

    logic [TAG_BITS-1:0] tag_reg;
    logic [ST_W-1:0]     status_reg, status_next;
    logic [RW-1:0]       rank_reg, rank_next;
    logic [IDX_W-1:0]    rank_ext;
    logic                present;
    logic                me;

    assign present  = (status_reg != ST_INVALID);
    assign rank_ext = IDX_W'(rank_reg);
    assign me       = (upd.way == MY_IDX);

    always_comb
    begin
        chain_out = chain_in;
        if (present && (tag_reg == tag) && !chain_in.hit)
        begin
            chain_out.hit        = 1'b1;
            chain_out.hit_way    = MY_IDX;
            chain_out.hit_rank   = rank_ext;
            chain_out.hit_status = status_reg;
        end
        if (!present && !chain_in.free_ok)
        begin
            chain_out.free_ok  = 1'b1;
            chain_out.free_way = MY_IDX;
        end
        if (present && (rank_reg == LAST_RANK))
        begin
            chain_out.lru_way = MY_IDX;
        end
    end

    always_comb
    begin
        status_next = status_reg;
        rank_next   = rank_reg;
        case (upd.kind)
            UPD_PROMOTE:
            begin
                if (me)
                begin
                    rank_next = '0;
                    if (upd.status_we)
                    begin
                        status_next = upd.status;
                    end
                end
                else if (present && (rank_ext < upd.pivot))
                begin
                    rank_next = RW'(rank_reg + 1'b1);
                end
            end
            UPD_RELEASE:
            begin
                if (me)
                begin
                    rank_next   = '0;
                    status_next = ST_INVALID;
                end
                else if (present && (rank_ext > upd.pivot))
                begin
                    rank_next = RW'(rank_reg - 1'b1);
                end
            end
            UPD_SET_STATUS:
            begin
                if (me)
                begin
                    status_next = upd.status;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_INVALID;
            rank_reg   <= '0;
        end
        else
        begin
            status_reg <= status_next;
            rank_reg   <= rank_next;
        end
    end

    // Tag is payload; only compared while the line is present.
    always_ff @(posedge clk)
    begin
        if ((upd.kind == UPD_PROMOTE) && me && upd.tag_we)
        begin
            tag_reg <= tag;
        end
    end

endmodule

FILE: rtl/lru_cache_set_core.sv
// Top level: one LRU-ordered cache set built as a row of line cells.
//
// Usage
//   req (sink): cmd, tag, new_status. A word is taken when valid and ready
//     are both high. cmd 0 read, 1 write, 2 set line status, 3 query status.
//   rsp (source): event_res, found, way, evicted, status_out; one word per
//     request, in request order.
// Timing and throughput
//   Responses appear on rsp in the cycle after the request is taken. One
//   request per cycle is sustained unless rsp stalls. The rate is set by the
//   tag compare in every cell, then the ripple through the cell chain (hit,
//   first free line, least recent line) and the rank update broadcast.
// Reset
//   All lines become invalid and ranks zero; rsp.valid drops. Tags are not
//   cleared and are only compared for present lines.
// Back-pressure
//   The response sits in an output register. While it is not taken, req.ready
//   is low and the set state holds; when it is taken, a new request may be
//   taken in the same cycle.
module lru_cache_set_core
    import lcs_pkg::*;
#(
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 52
) (
    input  logic       clk,
    input  logic       rst_n,
    lcs_req_if.sink    req,
    lcs_rsp_if.source  rsp
);

    localparam logic [IDX_W-1:0] LAST_RANK = IDX_W'(WAYS - 1);

    chain_t chain [WAYS+1];
    upd_t   upd;
    logic   accept;

    logic                 out_valid_reg;
    ev_t                  event_reg, event_next;
    logic                 found_reg, found_next;
    logic [OUT_WAY_W-1:0] way_reg, way_next;
    logic                 evicted_reg, evicted_next;
    logic [ST_W-1:0]      status_reg, status_next;

    cmd_t cmd;
    assign cmd = cmd_t'(req.cmd);

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < WAYS; g++)
        begin : g_cell
            lcs_line_cell #(
                .WAYS     (WAYS),
                .TAG_BITS (TAG_BITS),
                .IDX      (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .tag       (req.tag),
                .chain_in  (chain[g]),
                .chain_out (chain[g+1]),
                .upd       (upd)
            );
        end
    endgenerate

    // Decide the update and the response from the end of the chain.
    always_comb
    begin
        chain_t c;
        logic [IDX_W-1:0] way_full;
        c            = chain[WAYS];
        way_full     = '0;
        upd          = '0;
        upd.kind     = UPD_NONE;
        event_next   = EV_QUERY;
        found_next   = 1'b0;
        evicted_next = 1'b0;
        status_next  = ST_INVALID;
        case (cmd)
            CMD_READ, CMD_WRITE:
            begin
                upd.kind   = UPD_PROMOTE;
                upd.status = ST_VALID;
                if (c.hit)
                begin
                    event_next    = (cmd == CMD_WRITE) ? EV_WRITE_HIT : EV_READ_HIT;
                    found_next    = 1'b1;
                    way_full      = c.hit_way;
                    upd.pivot     = c.hit_rank;
                    upd.status_we = (cmd == CMD_WRITE);
                end
                else
                begin
                    // Fill or replace: the new line goes to the head, every
                    // present line moves back one rank.
                    event_next    = (cmd == CMD_WRITE) ? EV_WRITE_MISS : EV_READ_MISS;
                    upd.pivot     = LAST_RANK;
                    upd.status_we = 1'b1;
                    upd.tag_we    = 1'b1;
                    if (c.free_ok)
                    begin
                        way_full = c.free_way;
                    end
                    else
                    begin
                        way_full     = c.lru_way;
                        evicted_next = 1'b1;
                    end
                end
            end
            CMD_SET_STATUS:
            begin
                event_next = EV_STATUS_SET;
                if (c.hit)
                begin
                    found_next = 1'b1;
                    way_full   = c.hit_way;
                    upd.pivot  = c.hit_rank;
                    upd.status = req.new_status;
                    upd.kind   = (req.new_status == ST_INVALID) ? UPD_RELEASE
                                                                : UPD_SET_STATUS;
                end
            end
            CMD_QUERY:
            begin
                event_next = EV_QUERY;
                if (c.hit)
                begin
                    found_next  = 1'b1;
                    way_full    = c.hit_way;
                    status_next = c.hit_status;
                end
            end
            default:
            begin
            end
        endcase
        upd.way  = way_full;
        way_next = way_full[OUT_WAY_W-1:0];
        if (!accept)
        begin
            upd.kind = UPD_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg   <= event_next;
            found_reg   <= found_next;
            way_reg     <= way_next;
            evicted_reg <= evicted_next;
            status_reg  <= status_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.event_res  = event_reg;
    assign rsp.found      = found_reg;
    assign rsp.way        = way_reg;
    assign rsp.evicted    = evicted_reg;
    assign rsp.status_out = status_reg;

endmodule

FILE: rtl/lcs_checker.sv
// Port-level assertions for the LRU cache set core, bound to the top level.
module lcs_checker
    import lcs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] event_res,
    input logic       found,
    input logic       evicted,
    input logic [2:0] status_out
);

    // A held response keeps its event, found, evicted and status fields.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res) && $stable(found)
            && $stable(evicted) && $stable(status_out))
        else $error("response changed while stalled");

    // Every taken request shows a response in the next cycle.
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no response after accepted request");

    // Eviction only on a read or write miss.
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted |->
            !found && (event_res == EV_READ_MISS || event_res == EV_WRITE_MISS))
        else $error("eviction outside a miss");

    // Hit events agree with found.
    a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (event_res == EV_READ_HIT || event_res == EV_WRITE_HIT) |-> found)
        else $error("hit event without found");

    // Status reported only by a query that found the line.
    a_status_query: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status_out != ST_INVALID) |-> (event_res == EV_QUERY) && found)
        else $error("status reported outside a query hit");

endmodule

bind lru_cache_set_core lcs_checker u_lcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .event_res  (rsp.event_res),
    .found      (rsp.found),
    .evicted    (rsp.evicted),
    .status_out (rsp.status_out)
);
